### sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that must also hold during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/rbfd_pkg.sv
// Package for the ring buffer frame resync deframer: sizes, codes and payload types.
// Depends on nothing; used by ring_buffer_frame_resync_deframer.
package rbfd_pkg;

    // Ring store geometry. The depth must be a power of two.
    localparam int unsigned BUFFER_DEPTH = 1024;
    localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int unsigned CNT_W        = ADDR_W + 1;

    // Header plus the two length bytes.
    localparam logic [CNT_W-1:0] HEAD_BYTES = CNT_W'(3);

    // Depth and footer overhead at the width of a length compare.
    localparam logic [16:0] DEPTH_L   = 17'(BUFFER_DEPTH);
    localparam logic [16:0] FRAME_OVH = 17'd4;

    // Operation codes.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POLL = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_FOOTER = 2'd1;

    // Register reset values.
    localparam logic [7:0] HEADER_RESET = 8'd126;
    localparam logic [7:0] FOOTER_RESET = 8'd129;

    // Input request.
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_req;

    // Result.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic [10:0] fill_count;
    } t_out_rsp;

endpackage

### sv/ring_buffer_frame_resync_deframer.sv
// Top level of the ring buffer frame resync deframer: ring store and poll sequencer.
// Depends on rbfd_pkg and assert_macros.svh.
//
// Bytes are pushed into a 1024-byte ring store and popped by read; a poll
// resynchronises on header, little-endian 16-bit length, payload and footer,
// leaving the payload at the head when a good frame is found. One request is
// handled at a time and the next is taken once the result has been accepted.
// A poll drops every byte that is not a header, each with one store read and
// one header compare, as the single read port serves each step; it also
// drops a header whose length can never fit and a header with a bad footer.
// The scan ends on an empty store, on a header with fewer than three bytes
// held, on a frame that waits or on a frame found. All store reads go through
// one read port with a registered output, addressed as the head plus an offset.
`include "assert_macros.svh"

module ring_buffer_frame_resync_deframer
    import rbfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_rsp    o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_READ   = 9'b000000010,
        S_P_HEAD = 9'b000000100,
        S_P_CHK  = 9'b000001000,
        S_P_LEN1 = 9'b000010000,
        S_P_LEN2 = 9'b000100000,
        S_P_CMP  = 9'b001000000,
        S_P_FTR  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [7:0]          r_len_lo, n_len_lo;
    logic [15:0]         r_len, n_len;
    t_out_rsp            r_out, n_out;
    logic [7:0]          r_header, r_footer;
    logic [7:0]          r_rd_data;
    logic [7:0]          r_mem [BUFFER_DEPTH];

    logic                w_accept;
    logic [ADDR_W-1:0]   w_rd_off;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic                w_wr_en;
    logic [16:0]         w_need;
    logic                w_full;
    logic                w_empty;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CNT_W'(BUFFER_DEPTH));
    assign w_empty     = (r_count == '0);

    // Shared address adder: every store read is the head plus an offset.
    assign w_rd_addr = r_head + w_rd_off;
    assign w_wr_addr = r_head + r_count[ADDR_W-1:0];

    // Bytes a complete frame occupies: length plus header, length and footer.
    assign w_need = {1'b0, r_len} + FRAME_OVH;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_footer <= FOOTER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_HEADER) begin
                r_header <= i_cfg_data;
            end
            if (i_cfg_index == REG_FOOTER) begin
                r_footer <= i_cfg_data;
            end
        end
    end

    // Ring store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_in.rx_byte;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Sequencer: takes a request, walks the store for a poll, holds the result.
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_out    = r_out;
        w_rd_off = '0;
        w_wr_en  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out = '0;
                    if (i_in.operation == OP_PUSH) begin
                        if (w_full) begin
                            n_out.status = ST_ERROR;
                        end else begin
                            w_wr_en = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                        n_out.fill_count = 11'(n_count);
                        n_state = S_OUT;
                    end else if (i_in.operation == OP_POLL) begin
                        n_state = S_P_HEAD;
                    end else if (i_in.operation == OP_READ) begin
                        if (w_empty) begin
                            n_out.status     = ST_ERROR;
                            n_out.fill_count = 11'(r_count);
                            n_state = S_OUT;
                        end else begin
                            n_state = S_READ;
                        end
                    end else begin
                        // Unused code: no effect on the store.
                        n_out.fill_count = 11'(r_count);
                        n_state = S_OUT;
                    end
                end
            end

            // Head byte has been read; pop it.
            S_READ: begin
                n_out.data_byte  = r_rd_data;
                n_head           = r_head + ADDR_W'(1);
                n_count          = r_count - CNT_W'(1);
                n_out.fill_count = 11'(n_count);
                n_state = S_OUT;
            end

            // Start of one scan step: fetch the head byte.
            S_P_HEAD: begin
                if (w_empty) begin
                    n_out.status     = ST_WAIT;
                    n_out.fill_count = 11'(r_count);
                    n_state = S_OUT;
                end else begin
                    n_state = S_P_CHK;
                end
            end

            // Compare the head with the header value; fetch the low length byte.
            S_P_CHK: begin
                w_rd_off = ADDR_W'(1);
                if (r_rd_data != r_header) begin
                    n_head  = r_head + ADDR_W'(1);
                    n_count = r_count - CNT_W'(1);
                    n_state = S_P_HEAD;
                end else if (r_count < HEAD_BYTES) begin
                    n_out.status     = ST_WAIT;
                    n_out.fill_count = 11'(r_count);
                    n_state = S_OUT;
                end else begin
                    n_state = S_P_LEN1;
                end
            end

            // Low length byte arrives; fetch the high one.
            S_P_LEN1: begin
                w_rd_off = ADDR_W'(2);
                n_len_lo = r_rd_data;
                n_state  = S_P_LEN2;
            end

            S_P_LEN2: begin
                n_len   = {r_rd_data, r_len_lo};
                n_state = S_P_CMP;
            end

            // Decide completeness; fetch the footer of a complete frame.
            S_P_CMP: begin
                w_rd_off = ADDR_W'(r_len + 16'd3);
                if ({6'b0, r_count} >= w_need) begin
                    n_state = S_P_FTR;
                end else if ({1'b0, r_len} < DEPTH_L) begin
                    n_out.status     = ST_WAIT;
                    n_out.fill_count = 11'(r_count);
                    n_state = S_OUT;
                end else begin
                    // Length can never fit: treat the header as noise.
                    n_head  = r_head + ADDR_W'(1);
                    n_count = r_count - CNT_W'(1);
                    n_state = S_P_HEAD;
                end
            end

            // Footer check: a good frame leaves its payload at the head.
            S_P_FTR: begin
                if (r_rd_data == r_footer) begin
                    n_head             = r_head + ADDR_W'(HEAD_BYTES);
                    n_count            = r_count - HEAD_BYTES;
                    n_out.status       = ST_FRAME;
                    n_out.frame_length = r_len;
                    n_out.fill_count   = 11'(n_count);
                    n_state = S_OUT;
                end else begin
                    n_head  = r_head + ADDR_W'(1);
                    n_count = r_count - CNT_W'(1);
                    n_state = S_P_HEAD;
                end
            end

            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_len_lo <= n_len_lo;
        r_len    <= n_len;
        r_out    <= n_out;
    end

    // Checks on the sequencer and the store bookkeeping.
    `ASSERT_CLK(a_count_bound, (r_count <= CNT_W'(BUFFER_DEPTH)), "fill count above depth")
    `ASSERT_CLK(a_one_side, (!(o_in_ready && o_out_valid)), "ready while a result is held")
    `ASSERT_CLK(a_poll_start, (w_accept && (i_in.operation == OP_POLL)) |=> (r_state == S_P_HEAD), "poll did not start a scan")
    `ASSERT_CLK(a_frame_fits, (o_out_valid && (o_out.status == ST_FRAME)) |-> ({6'b0, r_count} >= ({1'b0, o_out.frame_length} + 17'd1)), "frame payload and footer not held")

endmodule

### bench/ring_buffer_frame_resync_deframer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ring_buffer_frame_resync_deframer: a scoreboard class predicts
// every result from its own copy of the ring store, and plain tasks drive the block.
// Depends on rbfd_pkg and the deframer RTL only.
module ring_buffer_frame_resync_deframer_test;
    import rbfd_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Register indexes beyond the list; writes to them must have no effect.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    // A poll over a full store can drop about a thousand bytes before its result.
    localparam int STALL_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_REQUESTS = 100;
    localparam int REPORT_LIMIT   = 40;

    // Predicts each result from the accepted requests and checks the block against it.
    class frame_scoreboard;
        logic [7:0]       ring_copy [BUFFER_DEPTH];
        logic [ADDR_W-1:0] head;
        logic [CNT_W-1:0] held;
        logic [7:0]       header_byte;
        logic [7:0]       footer_byte;
        t_out_rsp         expected_q [$];
        t_out_rsp         last_rsp;
        int               failures;
        int               results;
        int               frames;
        int               errors;

        function new();
            head        = '0;
            held        = '0;
            header_byte = HEADER_RESET;
            footer_byte = FOOTER_RESET;
            last_rsp    = '0;
            failures    = 0;
            results     = 0;
            frames      = 0;
            errors      = 0;
        endfunction

        function logic [7:0] peek(int unsigned offset);
            return ring_copy[ADDR_W'(head + offset)];
        endfunction

        function void drop(int unsigned n);
            if (n > held) n = held;
            head = ADDR_W'(head + n);
            held = held - CNT_W'(n);
        endfunction

        // Walks from the head until a frame is found or the scan has to wait.
        function t_out_rsp scan_for_frame();
            t_out_rsp    rsp;
            int unsigned len;
            rsp        = '0;
            rsp.status = ST_WAIT;
            while (held != 0) begin
                if (peek(0) != header_byte) begin
                    drop(1);
                    continue;
                end
                if (held < HEAD_BYTES) return rsp;
                len = {peek(2), peek(1)};
                if (held >= len + FRAME_OVH) begin
                    if (peek(len + HEAD_BYTES) == footer_byte) begin
                        drop(HEAD_BYTES);
                        rsp.status       = ST_FRAME;
                        rsp.frame_length = len[15:0];
                        return rsp;
                    end
                    drop(1);
                end else if (len < BUFFER_DEPTH) begin
                    return rsp;
                end else begin
                    drop(1);
                end
            end
            return rsp;
        endfunction

        // Updates the predicted state for an accepted request and queues its result.
        function void note_request(t_in_req req);
            t_out_rsp rsp;
            rsp = '0;
            case (req.operation)
                OP_PUSH: begin
                    if (held >= BUFFER_DEPTH) begin
                        rsp.status = ST_ERROR;
                    end else begin
                        ring_copy[ADDR_W'(head + held)] = req.rx_byte;
                        held = held + 1'b1;
                    end
                end
                OP_POLL: begin
                    rsp = scan_for_frame();
                end
                OP_READ: begin
                    if (held == 0) begin
                        rsp.status = ST_ERROR;
                    end else begin
                        rsp.data_byte = peek(0);
                        drop(1);
                    end
                end
                default: begin
                    rsp.status = ST_DONE;
                end
            endcase
            rsp.fill_count = held;
            if (rsp.status == ST_FRAME) frames++;
            if (rsp.status == ST_ERROR) errors++;
            last_rsp = rsp;
            expected_q.push_back(rsp);
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        // Compares one accepted result with the oldest outstanding prediction.
        function void check_result(t_out_rsp got);
            t_out_rsp want;
            results++;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t ns: result with no request outstanding, expected none, got %h",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) report("status", want.status, got.status);
            if (got.frame_length !== want.frame_length)
                report("frame_length", want.frame_length, got.frame_length);
            if (got.data_byte !== want.data_byte)
                report("data_byte", want.data_byte, got.data_byte);
            if (got.fill_count !== want.fill_count)
                report("fill_count", want.fill_count, got.fill_count);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_req     in_req    = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_rsp    out_rsp;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    int send_idle_pct = 8;
    int recv_idle_pct = 49;
    int requests_sent = 0;
    int quiet_cycles  = 0;

    frame_scoreboard sb;

    ring_buffer_frame_resync_deframer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // The receiver stalls at random, independently of the result valid.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every accepted result is checked against the prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_rsp);
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request, with an optional random gap, and waits until it is taken.
    task automatic send_request(input logic [1:0] op, input logic [7:0] value);
        t_in_req req;
        req.operation = op;
        req.rx_byte   = value;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (!in_ready);
        sb.note_request(req);
        requests_sent++;
    endtask

    // Stops sending and waits until every result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers, and the unused indexes, while the block is idle.
    task automatic write_setting(input logic [7:0] hdr, input logic [7:0] ftr);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_HEADER;
        cfg_data  <= hdr;
        @(posedge clk);
        cfg_index <= REG_FOOTER;
        cfg_data  <= ftr;
        @(posedge clk);
        cfg_index <= REG_SPARE_A;
        cfg_data  <= 8'($urandom_range(255));
        @(posedge clk);
        cfg_index <= REG_SPARE_B;
        cfg_data  <= 8'($urandom_range(255));
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.header_byte = hdr;
        sb.footer_byte = ftr;
    endtask

    // Reads until the store is empty, sometimes once more to provoke the empty error.
    task automatic drain_store();
        while (sb.held != 0) send_request(OP_READ, 8'($urandom_range(255)));
        if ($urandom_range(1) == 1) send_request(OP_READ, 8'($urandom_range(255)));
    endtask

    // One idling profile and one register setting, filled with mostly well-formed frames.
    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [7:0] hdr, input logic [7:0] ftr);
        int unsigned end_count;
        int unsigned pick;
        int unsigned len;
        int unsigned kind;
        int unsigned cut;
        int unsigned reads;
        logic [7:0]  frame_q [$];
        write_setting(hdr, ftr);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        end_count = requests_sent + PHASE_REQUESTS;
        while (requests_sent < end_count) begin
            pick = $urandom_range(99);
            if (sb.held > 700 || pick < 8) begin
                drain_store();
            end else if (pick < 20) begin
                // Loose requests of any code, the unused one included.
                repeat ($urandom_range(1, 4))
                    send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                // Some line noise, then a frame that may be broken, cut short or oversized.
                repeat ($urandom_range(2)) send_request(OP_PUSH, 8'($urandom_range(255)));
                len  = ($urandom_range(9) == 0) ? $urandom_range(16, 80) : $urandom_range(15);
                kind = $urandom_range(99);
                if (kind < 5) begin
                    send_request(OP_PUSH, sb.header_byte);
                    send_request(OP_PUSH, 8'($urandom_range(255)));
                    send_request(OP_PUSH, 8'($urandom_range(4, 255)));
                    repeat ($urandom_range(4)) send_request(OP_PUSH, 8'($urandom_range(255)));
                    send_request(OP_POLL, 8'($urandom_range(255)));
                end else begin
                    frame_q = {};
                    frame_q.push_back(sb.header_byte);
                    frame_q.push_back(len[7:0]);
                    frame_q.push_back(len[15:8]);
                    repeat (len) frame_q.push_back(8'($urandom_range(255)));
                    if (kind < 17)
                        frame_q.push_back(sb.footer_byte ^ 8'($urandom_range(1, 255)));
                    else
                        frame_q.push_back(sb.footer_byte);
                    cut = (kind < 27) ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
                    for (int i = 0; i < cut; i++) send_request(OP_PUSH, frame_q[i]);
                    send_request(OP_POLL, 8'($urandom_range(255)));
                    if (cut < frame_q.size()) begin
                        for (int i = cut; i < frame_q.size(); i++)
                            send_request(OP_PUSH, frame_q[i]);
                        send_request(OP_POLL, 8'($urandom_range(255)));
                    end
                end
                // Mostly take the payload and footer of a frame found, else a stray read or two.
                if (sb.last_rsp.status == ST_FRAME)
                    reads = ($urandom_range(9) < 8) ? sb.last_rsp.frame_length + 1
                                                    : $urandom_range(sb.last_rsp.frame_length);
                else
                    reads = $urandom_range(2);
                repeat (reads) send_request(OP_READ, 8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        logic [7:0]  hdr;
        logic [7:0]  value;
        logic [15:0] big_len;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset register values.
        send_request(OP_READ, 8'h00);
        send_request(OP_POLL, 8'h00);
        send_request(OP_UNUSED, 8'hFF);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'hFF);
        // A lone header after noise is too short to decode.
        send_request(OP_PUSH, HEADER_RESET);
        send_request(OP_POLL, 8'h00);
        // A plausible length with the payload still missing waits.
        send_request(OP_PUSH, 8'h02);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'hAA);
        send_request(OP_POLL, 8'h00);
        send_request(OP_PUSH, 8'h55);
        send_request(OP_PUSH, FOOTER_RESET);
        send_request(OP_POLL, 8'h00);
        repeat (3) send_request(OP_READ, 8'h00);
        // A wrong footer drops the header and the scan runs the store dry.
        send_request(OP_PUSH, HEADER_RESET);
        repeat (3) send_request(OP_PUSH, 8'h00);
        send_request(OP_POLL, 8'h00);
        // A length beyond the depth can never complete and is skipped.
        send_request(OP_PUSH, HEADER_RESET);
        repeat (2) send_request(OP_PUSH, 8'hFF);
        send_request(OP_POLL, 8'h00);
        // An empty payload with a good footer.
        send_request(OP_PUSH, HEADER_RESET);
        repeat (2) send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, FOOTER_RESET);
        send_request(OP_POLL, 8'h00);
        send_request(OP_READ, 8'h00);

        // Random phases: sender idles little, then the receiver, then neither.
        hdr = 8'($urandom_range(255));
        run_phase(8, 49, hdr, hdr ^ 8'($urandom_range(1, 255)));
        run_phase(49, 8, 8'h00, 8'hFF);
        run_phase(0, 0, 8'hFF, 8'h00);

        // One frame that fills the store to the last byte, then pushes on a full store.
        drain_store();
        big_len = 16'(BUFFER_DEPTH - FRAME_OVH);
        send_request(OP_PUSH, sb.header_byte);
        send_request(OP_PUSH, big_len[7:0]);
        send_request(OP_PUSH, big_len[15:8]);
        repeat (big_len) begin
            do value = 8'($urandom_range(255)); while (value == sb.header_byte);
            send_request(OP_PUSH, value);
        end
        send_request(OP_PUSH, sb.footer_byte);
        repeat (2) send_request(OP_PUSH, 8'($urandom_range(255)));
        send_request(OP_POLL, 8'h00);
        repeat (3) send_request(OP_READ, 8'h00);
        // No header remains, so this poll walks the whole store empty.
        send_request(OP_POLL, 8'h00);

        settle();
        $display("Covered %0d requests and %0d results: %0d frames found,",
                 requests_sent, sb.results, sb.frames);
        $display("%0d full or empty errors, over reset, three header and footer settings %s",
                 sb.errors, "and a full store.");
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
